/* rtl/core/lfs_pkg.sv */
// shared types and codes for the length fifo with statistics
// used by lfs_datapath, lfs_ctrl and length_fifo_with_statistics
// no dependencies
package lfs_pkg;

  // command codes carried in the func field
  localparam logic [2:0] FUNC_ENQ = 3'd0;
  localparam logic [2:0] FUNC_DEQ = 3'd1;
  localparam logic [2:0] FUNC_AVG = 3'd2;
  localparam logic [2:0] FUNC_MIN = 3'd3;
  localparam logic [2:0] FUNC_MAX = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // input item
  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] msg_length;
  } in_t;

  // result item
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] length_out;
    logic [23:0] average_q8;
  } out_t;

  // source of the result payload
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_READ,
    SRC_BEST,
    SRC_QUOT
  } src_t;

  // controller to datapath
  typedef struct packed {
    logic       load_cmd;
    logic       do_enq;
    logic       rd_head;
    logic       do_deq;
    logic       scan_start;
    logic       scan_run;
    logic       div_start;
    logic       out_load;
    logic [1:0] out_status;
    src_t       out_src;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] func;
    logic       empty;
    logic       full;
    logic       scan_done;
    logic       div_done;
  } stat_t;

endpackage

/* rtl/core/lfs_div.sv */
// iterative restoring divider, one quotient bit per cycle
// standalone, used by lfs_datapath for the q8 average
module lfs_div #(
  parameter int DW = 33,
  parameter int VW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int SW = $clog2(DW + 1);

  logic [SW-1:0] steps;
  logic          busy;
  logic [DW-1:0] dq;
  logic [VW-1:0] rem;

  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_dif;
  logic          take;

  always_comb begin
    rem_sh  = {rem, dq[DW-1]};
    take    = (rem_sh >= {1'b0, divisor});
    rem_dif = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      steps <= SW'(DW);
      dq    <= dividend;
      rem   <= '0;
    end else if (busy) begin
      dq    <= {dq[DW-2:0], take};
      rem   <= take ? rem_dif[VW-1:0] : rem_sh[VW-1:0];
      steps <= steps - 1'b1;
      if (steps == SW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quotient = dq;

endmodule

/* rtl/core/lfs_datapath.sv */
// datapath: length store, pointers, count, total, min/max scan, divider, result register
// depends on lfs_pkg and lfs_div
module lfs_datapath #(
  parameter int QUEUE_DEPTH = 256,
  parameter int LENGTH_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  lfs_pkg::in_t  in_data,
  input  lfs_pkg::cmd_t cmd,
  output lfs_pkg::stat_t stat,
  output lfs_pkg::out_t out_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = LENGTH_BITS + CW;
  localparam int DW = TW + 8;

  logic [LENGTH_BITS-1:0] store [QUEUE_DEPTH];

  logic [2:0]             cmd_func;
  logic [LENGTH_BITS-1:0] cmd_len;
  logic [PW-1:0]          head;
  logic [PW-1:0]          tail;
  logic [CW-1:0]          count;
  logic [TW-1:0]          total;
  logic [LENGTH_BITS-1:0] rd_data;

  logic [PW-1:0]          scan_ptr;
  logic [CW-1:0]          scan_left;
  logic                   scan_pend;
  logic                   scan_first;
  logic [LENGTH_BITS-1:0] best;

  logic [31:0]            len_ext;
  logic                   rd_en;
  logic [PW-1:0]          rd_addr;
  logic                   scan_issue;
  logic                   want_max;
  logic                   better;
  logic [TW-1:0]          rd_ext;
  logic                   div_done;
  logic [DW-1:0]          quot;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    len_ext    = 32'(in_data.msg_length);
    scan_issue = cmd.scan_run && (scan_left != '0);
    rd_en      = cmd.rd_head || scan_issue;
    rd_addr    = cmd.rd_head ? head : scan_ptr;
    want_max   = (cmd_func == lfs_pkg::FUNC_MAX);
    better     = want_max ? (rd_data > best) : (rd_data < best);
    rd_ext     = TW'(rd_data);
  end

  // length store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.do_enq) begin
      store[tail] <= cmd_len;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  // latched command
  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      cmd_func <= in_data.func;
      cmd_len  <= len_ext[LENGTH_BITS-1:0];
    end
  end

  // queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      total <= '0;
    end else if (cmd.do_enq) begin
      tail  <= ptr_inc(tail);
      count <= count + 1'b1;
      total <= total + TW'(cmd_len);
    end else if (cmd.do_deq) begin
      head  <= ptr_inc(head);
      count <= count - 1'b1;
      total <= (total >= rd_ext) ? total - rd_ext : '0;
    end
  end

  // min/max scan from oldest to newest, compare in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_left  <= '0;
      scan_pend  <= 1'b0;
      scan_first <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_ptr   <= head;
      scan_left  <= count;
      scan_pend  <= 1'b0;
      scan_first <= 1'b1;
    end else if (cmd.scan_run) begin
      scan_pend <= scan_issue;
      if (scan_issue) begin
        scan_ptr  <= ptr_inc(scan_ptr);
        scan_left <= scan_left - 1'b1;
      end
      if (scan_pend) begin
        scan_first <= 1'b0;
        if (scan_first || better) begin
          best <= rd_data;
        end
      end
    end
  end

  lfs_div #(
    .DW(DW),
    .VW(CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({total, 8'd0}),
    .divisor  (count),
    .done     (div_done),
    .quotient (quot)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.status <= cmd.out_status;
      case (cmd.out_src)
        lfs_pkg::SRC_READ: begin
          out_data.length_out <= 16'(rd_data);
          out_data.average_q8 <= '0;
        end
        lfs_pkg::SRC_BEST: begin
          out_data.length_out <= 16'(best);
          out_data.average_q8 <= '0;
        end
        lfs_pkg::SRC_QUOT: begin
          out_data.length_out <= '0;
          out_data.average_q8 <= 24'(quot);
        end
        default: begin
          out_data.length_out <= '0;
          out_data.average_q8 <= '0;
        end
      endcase
    end
  end

  always_comb begin
    stat.func      = cmd_func;
    stat.empty     = (count == '0);
    stat.full      = (count == CW'(QUEUE_DEPTH));
    stat.scan_done = (scan_left == '0) && !scan_pend;
    stat.div_done  = div_done;
  end

endmodule

/* rtl/core/lfs_ctrl.sv */
// controller state machine: sequences each command and owns the handshakes
// depends on lfs_pkg
module lfs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  lfs_pkg::stat_t stat,
  output lfs_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DEQ_WAIT,
    ST_SCAN,
    ST_DIV
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  always_comb begin
    logic       imm;
    logic [1:0] imm_status;
    logic       enq_req;
    logic       finish;

    imm        = 1'b0;
    imm_status = lfs_pkg::STAT_OK;
    enq_req    = 1'b0;
    finish     = 1'b0;
    cmd        = '0;
    cmd.out_src = lfs_pkg::SRC_NONE;
    in_ready   = 1'b0;
    state_next = state;
    slot_free  = !out_valid || out_ready;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_cmd = 1'b1;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (stat.func) inside
          lfs_pkg::FUNC_ENQ: begin
            imm = 1'b1;
            if (stat.full) begin
              imm_status = lfs_pkg::STAT_FULL;
            end else begin
              enq_req = 1'b1;
            end
          end
          lfs_pkg::FUNC_DEQ: begin
            if (stat.empty) begin
              imm        = 1'b1;
              imm_status = lfs_pkg::STAT_EMPTY;
            end else begin
              cmd.rd_head = 1'b1;
              state_next  = ST_DEQ_WAIT;
            end
          end
          lfs_pkg::FUNC_AVG: begin
            if (stat.empty) begin
              imm        = 1'b1;
              imm_status = lfs_pkg::STAT_EMPTY;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = ST_DIV;
            end
          end
          lfs_pkg::FUNC_MIN, lfs_pkg::FUNC_MAX: begin
            if (stat.empty) begin
              imm        = 1'b1;
              imm_status = lfs_pkg::STAT_EMPTY;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
          end
          default: begin
            imm = 1'b1;
          end
        endcase
        if (imm && slot_free) begin
          cmd.do_enq     = enq_req;
          cmd.out_load   = 1'b1;
          cmd.out_status = imm_status;
          finish         = 1'b1;
        end
      end
      ST_DEQ_WAIT: begin
        if (slot_free) begin
          cmd.do_deq   = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_src  = lfs_pkg::SRC_READ;
          finish       = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done && slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = lfs_pkg::SRC_BEST;
          finish       = 1'b1;
        end
      end
      ST_DIV: begin
        if (stat.div_done && slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = lfs_pkg::SRC_QUOT;
          finish       = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (finish) begin
      in_ready = 1'b1;
      if (in_valid) begin
        cmd.load_cmd = 1'b1;
        state_next   = ST_EXEC;
      end else begin
        state_next = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a result is only written into a free or draining output register
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  // a new command is taken only when the previous one is finishing
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> (state == ST_IDLE || cmd.out_load))
    else $error("command accepted while another is in progress");

  // a finished result leaves the output valid on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  // full and empty never hold together
  assert property (@(posedge clk) disable iff (rst)
    stat.full |-> !stat.empty)
    else $error("queue reports full and empty");

endmodule

/* rtl/core/length_fifo_with_statistics.sv */
// top level of the length fifo with statistics
// depends on lfs_pkg, lfs_ctrl, lfs_datapath (which holds lfs_div)
//
// A first-in first-out queue of message lengths that answers statistics
// queries. Each input transfer carries one command and produces exactly one
// result transfer, in order. Enqueue stores a length (low LENGTH_BITS bits)
// and adds it to a running total; a full queue drops the item with status
// full. Dequeue returns the oldest length. Average returns total * 256 /
// count truncated (Q.8), minimum and maximum return the extreme held
// length. Dequeue and queries on an empty queue return status empty;
// undefined commands return ok with zero payload. Enqueue, error results
// and undefined commands sustain one command per cycle while the result
// register is free or draining; dequeue loads the registered read of the
// length store; minimum and maximum scan one entry per cycle through the
// single store read port and compare in the cycle after the read; average
// waits for the divider, which produces one quotient bit per cycle.
// A result register separates the two sides, so the next command is
// accepted while a result waits for out_ready. The length store has no
// reset and needs no clearing pass.
module length_fifo_with_statistics #(
  parameter int QUEUE_DEPTH = 256,
  parameter int LENGTH_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lfs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lfs_pkg::out_t out_data
);

  // command and status between controller and datapath
  lfs_pkg::cmd_t  cmd;
  lfs_pkg::stat_t stat;

  // controller: handshakes and command sequencing
  lfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: store, pointers, total, scan, divider and result register
  lfs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

/* bench/lfs_checker.sv */
`timescale 1ns / 1ps
// result checker for the length fifo with statistics: mirrors the queue, predicts
// every result from the accepted commands and compares each result transfer in order
// depends on lfs_pkg
module lfs_checker #(
  parameter int QUEUE_DEPTH = 256,
  parameter int LENGTH_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  lfs_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  lfs_pkg::out_t out_data,
  output int            fail_count,
  output int            pending_count
);
  import lfs_pkg::*;

  logic [LENGTH_BITS-1:0] held_len [QUEUE_DEPTH];
  int unsigned            head_idx;
  int unsigned            tail_idx;
  int unsigned            held_count;
  longint unsigned        held_total;
  out_t                   pending_results [$];
  int                     mismatch_total = 0;
  int                     waiting = 0;

  assign fail_count    = mismatch_total;
  assign pending_count = waiting;

  task automatic report_mismatch(input string msg);
    mismatch_total++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // applies one command to the mirrored queue and returns its result
  function automatic out_t next_result(input in_t cmd);
    out_t                   res;
    logic [LENGTH_BITS-1:0] len;
    logic [LENGTH_BITS-1:0] best;
    logic [LENGTH_BITS-1:0] v;
    longint unsigned        quot;
    int unsigned            idx;
    res = '0;
    res.status = STAT_OK;
    len = LENGTH_BITS'(cmd.msg_length);
    case (cmd.func)
      FUNC_ENQ: begin
        if (held_count >= QUEUE_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          held_len[tail_idx] = len;
          tail_idx = (tail_idx + 1 >= QUEUE_DEPTH) ? 0 : tail_idx + 1;
          held_count++;
          held_total += len;
        end
      end
      FUNC_DEQ: begin
        if (held_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          v = held_len[head_idx];
          head_idx = (head_idx + 1 >= QUEUE_DEPTH) ? 0 : head_idx + 1;
          held_count--;
          held_total = (held_total >= v) ? held_total - v : 0;
          res.length_out = 16'(v);
        end
      end
      FUNC_AVG: begin
        if (held_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          quot = (held_total << 8) / held_count;
          res.average_q8 = quot[23:0];
        end
      end
      FUNC_MIN, FUNC_MAX: begin
        if (held_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          // walk the held entries oldest first
          idx  = head_idx;
          best = held_len[idx];
          for (int n = 0; n < held_count; n++) begin
            v = held_len[idx];
            if ((cmd.func == FUNC_MAX) ? (v > best) : (v < best)) best = v;
            idx = (idx + 1 >= QUEUE_DEPTH) ? 0 : idx + 1;
          end
          res.length_out = 16'(best);
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    out_t got;
    out_t want;
    if (rst) begin
      head_idx   = 0;
      tail_idx   = 0;
      held_count = 0;
      held_total = 0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing outstanding", got));
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
          if (got.length_out !== want.length_out)
            report_mismatch($sformatf("length_out %0d, wanted %0d",
                                      got.length_out, want.length_out));
          if (got.average_q8 !== want.average_q8)
            report_mismatch($sformatf("average_q8 %0d, wanted %0d",
                                      got.average_q8, want.average_q8));
        end
      end
      if (in_valid && in_ready) pending_results.push_back(next_result(in_data));
    end
    waiting = pending_results.size();
  end

endmodule

/* bench/tb_length_fifo_with_statistics.sv */
`timescale 1ns / 1ps
// top of the length fifo with statistics testbench: clock, reset, command stimulus,
// random idling on both channels and the verdict
// depends on lfs_pkg, length_fifo_with_statistics and lfs_checker
module tb_length_fifo_with_statistics;
  import lfs_pkg::*;

  localparam int QUEUE_DEPTH     = 256;
  localparam int LENGTH_BITS     = 16;
  localparam int ITEMS_PER_PHASE = 345;
  // a full-queue min or max scan is the longest single result
  localparam int DRAIN_CYCLES    = 300;
  // slowest run: every command a full scan plus sender gaps and receiver stalls,
  // with CYCLE_LIMIT set several times above it
  localparam longint CYCLE_LIMIT = 2_000_000;

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   in_valid  = 1'b0;
  logic   in_ready;
  in_t    in_data   = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  out_t   out_data;
  int     fail_count;
  int     pending_count;

  // idling percentages for the current phase
  int     sender_idle_pct    = 0;
  int     receiver_stall_pct = 0;

  // command mix state: grow the queue toward a target, then shrink it
  int     occupancy    = 0;
  bit     growing      = 1'b0;
  bit     force_full   = 1'b0;
  int     fill_target  = 0;
  int     drain_target = 0;
  int     linger       = 0;
  longint cycle_count  = 0;

  always #5 clk = ~clk;

  length_fifo_with_statistics #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .LENGTH_BITS(LENGTH_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  lfs_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .LENGTH_BITS(LENGTH_BITS)
  ) result_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_length_fifo_with_statistics failed");
      $finish;
    end
  end

  // receiver side: stall at random, changed on the falling edge
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= receiver_stall_pct);
  end

  // lengths lean on the extremes, the rest is uniform
  function automatic logic [15:0] rand_len();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(15));
      3:       return 16'hFFFF - 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  // picks the next random command; mostly pushes while growing, pops while shrinking
  function automatic in_t next_cmd();
    in_t cmd;
    int  pick;
    if (growing && occupancy >= fill_target) begin
      if (linger > 0) begin
        linger--;
      end else begin
        growing      = 1'b0;
        drain_target = ($urandom_range(2) == 0) ? $urandom_range(occupancy) : 0;
        linger       = $urandom_range(1, 5);
      end
    end else if (!growing && occupancy <= drain_target) begin
      if (linger > 0) begin
        linger--;
      end else begin
        growing     = 1'b1;
        fill_target = (force_full || $urandom_range(5) == 0) ? QUEUE_DEPTH
                                                             : $urandom_range(1, 48);
        force_full  = 1'b0;
        linger      = $urandom_range(1, 5);
      end
    end
    pick           = $urandom_range(99);
    cmd.msg_length = rand_len();
    if (pick < 70) begin
      cmd.func = growing ? FUNC_ENQ : FUNC_DEQ;
    end else if (pick < 80) begin
      cmd.func = growing ? FUNC_DEQ : FUNC_ENQ;
    end else if (pick < 95) begin
      case ($urandom_range(2))
        0:       cmd.func = FUNC_AVG;
        1:       cmd.func = FUNC_MIN;
        default: cmd.func = FUNC_MAX;
      endcase
    end else begin
      // codes above the last defined command
      cmd.func = FUNC_MAX + 3'($urandom_range(1, 3));
    end
    return cmd;
  endfunction

  // one input transfer, with optional idle cycles ahead of it
  task automatic send_cmd(input in_t cmd);
    bit taken;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = cmd;
    taken    = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = in_ready;
    end
    @(negedge clk);
    // track fill level so the mix can steer toward full and empty
    case (cmd.func)
      FUNC_ENQ: if (occupancy < QUEUE_DEPTH) occupancy++;
      FUNC_DEQ: if (occupancy > 0) occupancy--;
      default: begin
      end
    endcase
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty queue errors, undefined codes, extreme lengths
    send_cmd(in_t'{FUNC_DEQ, 16'h0000});
    send_cmd(in_t'{FUNC_AVG, 16'h0000});
    send_cmd(in_t'{FUNC_MIN, 16'hFFFF});
    send_cmd(in_t'{FUNC_MAX, 16'hFFFF});
    send_cmd(in_t'{FUNC_MAX + 3'd1, 16'hFFFF});
    send_cmd(in_t'{FUNC_MAX + 3'd2, 16'hAAAA});
    send_cmd(in_t'{FUNC_MAX + 3'd3, 16'h5555});
    send_cmd(in_t'{FUNC_ENQ, 16'h0000});
    send_cmd(in_t'{FUNC_AVG, 16'h0000});
    send_cmd(in_t'{FUNC_MIN, 16'h0000});
    send_cmd(in_t'{FUNC_MAX, 16'h0000});
    send_cmd(in_t'{FUNC_ENQ, 16'hFFFF});
    send_cmd(in_t'{FUNC_AVG, 16'h0000});
    send_cmd(in_t'{FUNC_MIN, 16'h0000});
    send_cmd(in_t'{FUNC_MAX, 16'h0000});
    send_cmd(in_t'{FUNC_ENQ, 16'h0001});
    send_cmd(in_t'{FUNC_AVG, 16'h0000});
    send_cmd(in_t'{FUNC_DEQ, 16'hFFFF});
    send_cmd(in_t'{FUNC_MIN, 16'h0000});
    send_cmd(in_t'{FUNC_DEQ, 16'h0000});
    send_cmd(in_t'{FUNC_MAX, 16'h0000});
    send_cmd(in_t'{FUNC_DEQ, 16'h0000});
    send_cmd(in_t'{FUNC_DEQ, 16'h0000});
    send_cmd(in_t'{FUNC_AVG, 16'hFFFF});

    // random: four idling phases, full queue forced in two of them
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 68;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 68;
        end
        default: begin
          sender_idle_pct    = 12;
          receiver_stall_pct = 12;
        end
      endcase
      force_full = (phase == 0 || phase == 2);
      repeat (ITEMS_PER_PHASE) send_cmd(next_cmd());
    end
    in_valid = 1'b0;

    // let every outstanding result arrive, then watch for strays
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_length_fifo_with_statistics passed");
    end else begin
      $display("tb_length_fifo_with_statistics failed");
    end
    $finish;
  end

endmodule
